### design/ibac_pkg.sv
// Shared types and constants for the block average downsampler.
// No dependencies; used by img_block_average_constraint and its checker.

package ibac_pkg;

   localparam int MAX_COLS  = 4096;
   localparam int MAX_BLOCK = 16;
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int BLK_W     = $clog2(MAX_BLOCK);
   localparam int SUM_W     = 24;
   localparam int CNT_W     = 9;
   localparam int BSZ_W     = 5;
   localparam int NCOL_W    = 13;
   localparam int RECIP_W   = 17;
   localparam int PROD_W    = SUM_W + 32;
   localparam int FRAC_W    = CNT_W + RECIP_W;
   localparam int ADDR_W    = 5;

   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic [FRAC_W-1:0]  HALF_FRAC = FRAC_W'(32'h8000);

   typedef enum logic [1:0] {
      MODE_RAW         = 2'd0,
      MODE_DECODED     = 2'd1,
      MODE_CONSTRAINED = 2'd2,
      MODE_FRACTION    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_BLOCK_SIZE  = 3'd0,
      REG_OUT_COLUMNS = 3'd1,
      REG_OUTPUT_MODE = 3'd2,
      REG_DATA_GAIN   = 3'd3,
      REG_AREA_RECIP  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               grid_start;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               is_nan;
      logic [CNT_W-1:0]   constraint_count;
      logic [COL_W-1:0]   out_column;
      logic               last_in_row;
      logic signed [31:0] running_min;
      logic signed [31:0] running_max;
   } rsp_data_type;

   // Item held in the input stage, waiting for its line entry to be combined
   typedef struct packed {
      logic signed [15:0] sample;
      logic               constrained;
      logic [COL_W-1:0]   col;
      logic               block_first;
      logic               group_open;
      logic               col_last;
      logic               emit;
      logic               line_last;
      logic               grid;
   } a_item_type;

endpackage

### design/img_block_average_constraint.sv
// An item moves through stages A, B and C before a result is registered on rsp_valid.
// Throughput: one item per cycle; one line buffer read and at most one write per cycle
// carry the per-column sums, with a bypass for the entry written in the same cycle.
// The pipeline holds only while a result sits on the output and rsp_stall is high.
// Reset (synchronous): registers return to their defaults, counters to zero, min/max
// to their extremes; the line buffer keeps its contents and is not cleared.
// Block average downsampler with APB-style register port; uses ibac_pkg.

module img_block_average_constraint
   import ibac_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_data_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_data_type        rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   // ---------------- registers ----------------
   logic [BSZ_W-1:0]    block_size_ff;
   logic [NCOL_W-1:0]   out_columns_ff;
   mode_type            output_mode_ff;
   logic signed [31:0]  data_gain_ff;
   logic [RECIP_W-1:0]  area_recip_ff;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= BSZ_W'(1);
         out_columns_ff <= NCOL_W'(1);
         output_mode_ff <= MODE_RAW;
         data_gain_ff   <= 32'sd65536;
         area_recip_ff  <= RECIP_W'(65536);
      end else if (csr_write) begin
         case (reg_index_type'(csr_paddr[4:2]))
            REG_BLOCK_SIZE:  block_size_ff  <= csr_pwdata[BSZ_W-1:0];
            REG_OUT_COLUMNS: out_columns_ff <= csr_pwdata[NCOL_W-1:0];
            REG_OUTPUT_MODE: output_mode_ff <= mode_type'(csr_pwdata[1:0]);
            REG_DATA_GAIN:   data_gain_ff   <= csr_pwdata;
            REG_AREA_RECIP:  area_recip_ff  <= csr_pwdata[RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[4:2]))
         REG_BLOCK_SIZE:  csr_prdata = 32'(block_size_ff);
         REG_OUT_COLUMNS: csr_prdata = 32'(out_columns_ff);
         REG_OUTPUT_MODE: csr_prdata = 32'(output_mode_ff);
         REG_DATA_GAIN:   csr_prdata = data_gain_ff;
         REG_AREA_RECIP:  csr_prdata = 32'(area_recip_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic rsp_valid_ff;
   logic advance;
   logic accept;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // ---------------- block counters ----------------
   logic [COL_W-1:0]  col_idx_ff, col_idx_in, col_cur;
   logic [BLK_W-1:0]  bcol_ff, bcol_in, bcol_cur;
   logic [BLK_W-1:0]  brow_ff, brow_in, brow_cur;
   logic [BSZ_W-1:0]  n_eff, bcol_inc, brow_inc;
   logic [NCOL_W-1:0] cols_eff, col_inc;
   logic              col_last, row_last, line_last;
   logic signed [15:0] sample_dec;
   logic               constrained;
   a_item_type         a_in;

   always_comb begin
      if (block_size_ff == '0)
         n_eff = BSZ_W'(1);
      else if (block_size_ff > BSZ_W'(MAX_BLOCK))
         n_eff = BSZ_W'(MAX_BLOCK);
      else
         n_eff = block_size_ff;

      if (out_columns_ff == '0)
         cols_eff = NCOL_W'(1);
      else if (out_columns_ff > NCOL_W'(MAX_COLS))
         cols_eff = NCOL_W'(MAX_COLS);
      else
         cols_eff = out_columns_ff;

      col_cur  = req_data.grid_start ? '0 : col_idx_ff;
      bcol_cur = req_data.grid_start ? '0 : bcol_ff;
      brow_cur = req_data.grid_start ? '0 : brow_ff;

      bcol_inc = BSZ_W'(bcol_cur) + BSZ_W'(1);
      brow_inc = BSZ_W'(brow_cur) + BSZ_W'(1);
      col_inc  = NCOL_W'(col_cur) + NCOL_W'(1);

      col_last  = bcol_inc >= n_eff;
      row_last  = brow_inc >= n_eff;
      line_last = col_inc >= cols_eff;

      col_idx_in = col_cur;
      brow_in    = brow_cur;
      if (!col_last) begin
         bcol_in = bcol_inc[BLK_W-1:0];
      end else begin
         bcol_in = '0;
         if (line_last) begin
            col_idx_in = '0;
            brow_in    = row_last ? '0 : brow_inc[BLK_W-1:0];
         end else begin
            col_idx_in = col_inc[COL_W-1:0];
         end
      end

      // outside raw mode, an odd sample is a constraint: drop its low bit
      constrained = (output_mode_ff != MODE_RAW) && req_data.sample[0];
      sample_dec  = constrained ? {req_data.sample[15:1], 1'b0} : req_data.sample;

      a_in.sample      = sample_dec;
      a_in.constrained = constrained;
      a_in.col         = col_cur;
      a_in.block_first = (brow_cur == '0) && (bcol_cur == '0);
      a_in.group_open  = (bcol_cur == '0);
      a_in.col_last    = col_last;
      a_in.emit        = col_last && row_last;
      a_in.line_last   = line_last;
      a_in.grid        = req_data.grid_start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_idx_ff <= '0;
         bcol_ff    <= '0;
         brow_ff    <= '0;
      end else if (accept) begin
         col_idx_ff <= col_idx_in;
         bcol_ff    <= bcol_in;
         brow_ff    <= brow_in;
      end
   end

   // ---------------- line buffer and stage A ----------------
   logic [SUM_W+CNT_W-1:0] line_mem [MAX_COLS];
   logic [SUM_W+CNT_W-1:0] rd_ff;
   a_item_type             a_ff;
   logic                   a_valid_ff;

   logic signed [SUM_W-1:0] acc_sum_ff, sum_base, sum_new;
   logic [CNT_W-1:0]        acc_cnt_ff, cnt_base, cnt_new;
   logic [COL_W-1:0]        last_col_ff;
   logic                    prev_wrote_ff;
   logic                    bypass;

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff <= line_mem[col_cur];
         if (a_valid_ff && a_ff.col_last)
            line_mem[a_ff.col] <= {sum_new, cnt_new};
      end
   end

   always_comb begin
      // entry written at the edge of our read: rd_ff is stale, take the accumulator
      bypass = prev_wrote_ff && (last_col_ff == a_ff.col);
      if (a_ff.block_first) begin
         sum_base = '0;
         cnt_base = '0;
      end else if (a_ff.group_open && !bypass) begin
         sum_base = rd_ff[SUM_W+CNT_W-1:CNT_W];
         cnt_base = rd_ff[CNT_W-1:0];
      end else begin
         sum_base = acc_sum_ff;
         cnt_base = acc_cnt_ff;
      end
      sum_new = sum_base + SUM_W'(a_ff.sample);
      cnt_new = cnt_base + CNT_W'(a_ff.constrained);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         prev_wrote_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= accept;
         if (a_valid_ff)
            prev_wrote_ff <= a_ff.col_last;
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         a_ff <= a_in;
      if (advance && a_valid_ff) begin
         acc_sum_ff  <= sum_new;
         acc_cnt_ff  <= cnt_new;
         last_col_ff <= a_ff.col;
      end
   end

   // ---------------- stage B: block totals ----------------
   logic                    b_valid_ff, b_emit_ff, b_line_last_ff, b_grid_ff;
   logic signed [SUM_W-1:0] b_sum_ff;
   logic [CNT_W-1:0]        b_cnt_ff;
   logic [COL_W-1:0]        b_col_ff;

   always_ff @(posedge clock) begin
      if (reset)
         b_valid_ff <= 1'b0;
      else if (advance)
         b_valid_ff <= a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance && a_valid_ff) begin
         b_emit_ff      <= a_ff.emit;
         b_line_last_ff <= a_ff.line_last;
         b_grid_ff      <= a_ff.grid;
         b_sum_ff       <= sum_new;
         b_cnt_ff       <= cnt_new;
         b_col_ff       <= a_ff.col;
      end
   end

   // ---------------- stage C: products ----------------
   logic                     c_valid_ff, c_emit_ff, c_line_last_ff, c_grid_ff;
   logic signed [PROD_W-1:0] c_prod_ff, prod_in;
   logic [FRAC_W-1:0]        c_frac_ff, frac_in;
   logic [CNT_W-1:0]         c_cnt_ff;
   logic [COL_W-1:0]         c_col_ff;

   assign prod_in = PROD_W'(b_sum_ff) * PROD_W'(data_gain_ff);
   assign frac_in = FRAC_W'(b_cnt_ff) * FRAC_W'(area_recip_ff);

   always_ff @(posedge clock) begin
      if (reset)
         c_valid_ff <= 1'b0;
      else if (advance)
         c_valid_ff <= b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance && b_valid_ff) begin
         c_emit_ff      <= b_emit_ff;
         c_line_last_ff <= b_line_last_ff;
         c_grid_ff      <= b_grid_ff;
         c_prod_ff      <= prod_in;
         c_frac_ff      <= frac_in;
         c_cnt_ff       <= b_cnt_ff;
         c_col_ff       <= b_col_ff;
      end
   end

   // ---------------- stage D: saturate, min/max, output ----------------
   logic signed [31:0] min_ff, min_in, max_ff, max_in, min_base, max_base;
   logic signed [31:0] data_sat, value_calc, value_out;
   logic               nan, counted;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   always_comb begin
      if ((c_prod_ff[PROD_W-1:31] == '0) || (c_prod_ff[PROD_W-1:31] == '1))
         data_sat = c_prod_ff[31:0];
      else if (c_prod_ff[PROD_W-1])
         data_sat = VALUE_MIN;
      else
         data_sat = VALUE_MAX;

      value_calc = (output_mode_ff == MODE_FRACTION) ? 32'(c_frac_ff) : data_sat;
      nan        = (output_mode_ff == MODE_CONSTRAINED) && (c_frac_ff < HALF_FRAC);
      value_out  = nan ? '0 : value_calc;
      counted    = c_emit_ff && !nan;

      min_base = c_grid_ff ? VALUE_MAX : min_ff;
      max_base = c_grid_ff ? VALUE_MIN : max_ff;
      min_in   = (counted && (value_calc < min_base)) ? value_calc : min_base;
      max_in   = (counted && (value_calc > max_base)) ? value_calc : max_base;

      rsp_data_in.value            = value_out;
      rsp_data_in.is_nan           = nan;
      rsp_data_in.constraint_count = c_cnt_ff;
      rsp_data_in.out_column       = c_col_ff;
      rsp_data_in.last_in_row      = c_line_last_ff;
      rsp_data_in.running_min      = min_in;
      rsp_data_in.running_max      = max_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         min_ff       <= VALUE_MAX;
         max_ff       <= VALUE_MIN;
      end else if (advance) begin
         rsp_valid_ff <= c_valid_ff && c_emit_ff;
         if (c_valid_ff) begin
            min_ff <= min_in;
            max_ff <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && c_valid_ff && c_emit_ff)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/ibac_checker.sv
// Port-level checks for img_block_average_constraint, attached by bind.
// Depends on ibac_pkg for the result item type.

module ibac_checker
   import ibac_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data
);

   // a held result item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_nan_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_nan |-> rsp_data.value == 32'sd0)
      else $error("NaN result carries a nonzero value");

   // a counted value must lie inside the running range it just updated
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_nan |->
         (rsp_data.running_min <= rsp_data.value) &&
         (rsp_data.value <= rsp_data.running_max))
      else $error("value outside running min/max");

endmodule

bind img_block_average_constraint ibac_checker u_ibac_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for img_block_average_constraint: streams pixels, predicts each
// block average, and checks every output pixel. Depends on ibac_pkg.

module testbench
   import ibac_pkg::*;
();

   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 400;
   localparam int RANDOM_ITEMS = 1550;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_data_type       req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_data_type       rsp_data;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]  csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   img_block_average_constraint dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow of the register file
   logic [BSZ_W-1:0]    blk_size = 5'd1;
   logic [NCOL_W-1:0]   n_cols   = 13'd1;
   mode_type            out_mode = MODE_RAW;
   logic signed [31:0]  gain_q   = 32'sd65536;
   logic [RECIP_W-1:0]  area_rcp = 17'd65536;

   // Shadow of the block state
   logic signed [SUM_W-1:0] block_sums   [MAX_COLS];
   logic [CNT_W-1:0]        block_counts [MAX_COLS];
   int                      col_pos = 0;
   int                      blk_col = 0;
   int                      blk_row = 0;
   logic signed [31:0]      grid_min = VALUE_MAX;
   logic signed [31:0]      grid_max = VALUE_MIN;

   rsp_data_type pending_averages[$];
   int           bad_fields = 0;
   int           random_items = 0;
   int           burst_left = 0;
   bit           steady_input = 1'b0;
   bit           hold_request = 1'b0;
   int           hold_left = 0;
   int           stall_cycle = 0;
   int           quiet_cycles = 0;

   function automatic logic signed [31:0] clamp32(input longint x);
      if (x > longint'(VALUE_MAX)) return VALUE_MAX;
      if (x < longint'(VALUE_MIN)) return VALUE_MIN;
      return 32'(x);
   endfunction

   // Fold one pixel into the shadow line buffer; queue an output pixel when
   // the pixel closes a block.
   function automatic void average_pixel(input logic signed [15:0] pix, input logic grid);
      int                 n, cols, s, c, col;
      logic               col_last, row_last, line_last, nan;
      longint             frac;
      logic signed [31:0] v;
      logic [CNT_W-1:0]   cnt;
      rsp_data_type       r;
      n = (blk_size == 0) ? 1 : ((blk_size > MAX_BLOCK) ? MAX_BLOCK : int'(blk_size));
      cols = (n_cols == 0) ? 1 : ((n_cols > MAX_COLS) ? MAX_COLS : int'(n_cols));
      if (grid) begin
         col_pos = 0;
         blk_col = 0;
         blk_row = 0;
         grid_min = VALUE_MAX;
         grid_max = VALUE_MIN;
      end
      s = pix;
      c = 0;
      if (out_mode != MODE_RAW && s[0]) begin
         c = 1;
         s = s - 1;
      end
      col = col_pos % MAX_COLS;
      if (blk_row == 0 && blk_col == 0) begin
         block_sums[col] = SUM_W'(s);
         block_counts[col] = CNT_W'(c);
      end else begin
         block_sums[col] = SUM_W'(block_sums[col] + s);
         block_counts[col] = CNT_W'(block_counts[col] + c);
      end
      col_last = (blk_col + 1 >= n);
      row_last = (blk_row + 1 >= n);
      line_last = (col_pos + 1 >= cols);
      if (!col_last) begin
         blk_col++;
         return;
      end
      blk_col = 0;
      if (line_last) begin
         col_pos = 0;
         blk_row = row_last ? 0 : blk_row + 1;
      end else begin
         col_pos++;
      end
      if (!row_last) return;

      cnt = block_counts[col];
      frac = longint'(cnt) * longint'(area_rcp);
      nan = 1'b0;
      if (out_mode == MODE_FRACTION) begin
         v = clamp32(frac);
      end else begin
         v = clamp32(longint'(block_sums[col]) * longint'(gain_q));
         nan = (out_mode == MODE_CONSTRAINED) && (frac < 32768);
      end
      if (nan) begin
         v = '0;
      end else begin
         if (v < grid_min) grid_min = v;
         if (v > grid_max) grid_max = v;
      end
      r.value = v;
      r.is_nan = nan;
      r.constraint_count = cnt;
      r.out_column = COL_W'(col);
      r.last_in_row = line_last;
      r.running_min = grid_min;
      r.running_max = grid_max;
      pending_averages.push_back(r);
   endfunction

   function automatic logic signed [15:0] rand_sample(input int odd_pct);
      logic signed [15:0] s;
      case ($urandom_range(0, 9))
         0: s = 16'sh7FFF;
         1: s = 16'sh8000;
         2: s = 16'($urandom_range(0, 31)) - 16'd16;
         default: s = 16'($urandom);
      endcase
      s[0] = ($urandom_range(0, 99) < odd_pct);
      return s;
   endfunction

   // Offer one pixel; returns in the time step of its acceptance.
   task automatic send_pixel(input logic signed [15:0] pix, input logic grid);
      int           gap;
      req_data_type item;
      gap = 0;
      if (!steady_input) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.sample = pix;
      item.grid_start = grid;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      average_pixel(pix, grid);
   endtask

   // Drop valid, let all output pixels drain, then cover pixels still in flight.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'(4 * idx);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_BLOCK_SIZE:  blk_size = val[BSZ_W-1:0];
         REG_OUT_COLUMNS: n_cols = val[NCOL_W-1:0];
         REG_OUTPUT_MODE: out_mode = mode_type'(val[1:0]);
         REG_DATA_GAIN:   gain_q = val;
         REG_AREA_RECIP:  area_rcp = val[RECIP_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input int bs, input int cols, input mode_type mode,
                             input logic [31:0] gain, input logic [RECIP_W-1:0] recip);
      write_reg(REG_BLOCK_SIZE, 32'(bs));
      write_reg(REG_OUT_COLUMNS, 32'(cols));
      write_reg(REG_OUTPUT_MODE, 32'(mode));
      write_reg(REG_DATA_GAIN, gain);
      write_reg(REG_AREA_RECIP, 32'(recip));
   endtask

   // Register defaults: 1x1 blocks, one column, raw data, unity gain.
   task automatic test_reset_defaults();
      send_pixel(16'sh7FFF, 1'b1);
      send_pixel(16'sh8000, 1'b0);
      send_pixel(16'sh0000, 1'b0);
      send_pixel(-16'sd1, 1'b0);
      settle_block();
   endtask

   // Each mode but raw once, with saturation both ways and a block size of zero.
   task automatic test_operations();
      set_config(0, 2, MODE_DECODED, 32'h7FFF_FFFF, 17'd65536);
      send_pixel(-16'sd3, 1'b1);
      send_pixel(16'sh7FFF, 1'b0);
      settle_block();
      write_reg(REG_OUTPUT_MODE, 32'(MODE_CONSTRAINED));
      write_reg(REG_DATA_GAIN, 32'h8000_0000);
      send_pixel(-16'sd32767, 1'b1);
      send_pixel(16'sd100, 1'b0);
      settle_block();
      write_reg(REG_OUTPUT_MODE, 32'(MODE_FRACTION));
      write_reg(REG_AREA_RECIP, 32'h0001_FFFF);
      send_pixel(16'sd1, 1'b1);
      send_pixel(16'sh8000, 1'b0);
      settle_block();
   endtask

   // Exactly half constrained keeps the data; one short of half gives NaN.
   task automatic test_half_threshold();
      set_config(2, 1, MODE_CONSTRAINED, 32'd16384, 17'd16384);
      send_pixel(16'sd1, 1'b1);
      send_pixel(16'sd3, 1'b0);
      send_pixel(16'sd2, 1'b0);
      send_pixel(16'sd4, 1'b0);
      send_pixel(16'sd5, 1'b0);
      send_pixel(16'sd2, 1'b0);
      send_pixel(16'sd4, 1'b0);
      send_pixel(16'sd6, 1'b0);
      settle_block();
   endtask

   // Shrink the column count and the block size while counters sit past
   // their new last positions.
   task automatic test_counter_overrun();
      set_config(1, 8, MODE_RAW, 32'd65536, 17'd65536);
      send_pixel(rand_sample(50), 1'b1);
      send_pixel(rand_sample(50), 1'b0);
      send_pixel(rand_sample(50), 1'b0);
      settle_block();
      write_reg(REG_OUT_COLUMNS, 32'd2);
      send_pixel(rand_sample(50), 1'b0);
      settle_block();
      set_config(3, 1, MODE_DECODED, 32'd7282, 17'd7282);
      send_pixel(rand_sample(50), 1'b1);
      repeat (6) send_pixel(rand_sample(50), 1'b0);
      settle_block();
      write_reg(REG_BLOCK_SIZE, 32'd2);
      send_pixel(rand_sample(50), 1'b0);
      settle_block();
   endtask

   // Hold the output off long enough for the input to back up.
   task automatic test_backpressure();
      set_config(1, 5, MODE_RAW, 32'd65536, 17'd65536);
      steady_input = 1'b1;
      hold_request = 1'b1;
      send_pixel(rand_sample(50), 1'b1);
      repeat (79) send_pixel(rand_sample(50), 1'b0);
      settle_block();
      steady_input = 1'b0;
   endtask

   task automatic test_random_phases();
      int                 bs, n_eff, cols, cols_eff, rows, odd_pct, count;
      mode_type           mode;
      logic [31:0]        gain;
      logic [RECIP_W-1:0] recip;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: bs = $urandom_range(1, 4);
            7: bs = $urandom_range(5, 15);
            default: begin
               case ($urandom_range(0, 3))
                  0: bs = 0;
                  1: bs = 16;
                  default: bs = $urandom_range(17, 31);
               endcase
            end
         endcase
         n_eff = (bs == 0) ? 1 : ((bs > MAX_BLOCK) ? MAX_BLOCK : bs);
         if (n_eff >= 8) begin
            cols = $urandom_range(0, 2);
         end else begin
            case ($urandom_range(0, 9))
               0: cols = 0;
               1, 2: cols = $urandom_range(9, 40);
               default: cols = $urandom_range(1, 8);
            endcase
         end
         cols_eff = (cols == 0) ? 1 : cols;
         rows = (n_eff >= 8) ? 1 : $urandom_range(1, 3);
         mode = mode_type'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0: gain = 32'(65536 / (n_eff * n_eff));
            1: gain = $urandom;
            2: gain = 32'h7FFF_FFFF;
            3: gain = 32'h8000_0000;
            4: gain = 32'($urandom_range(0, 4095)) - 32'd2048;
            default: gain = -32'(65536 / (n_eff * n_eff));
         endcase
         case ($urandom_range(0, 4))
            0: recip = '0;
            1: recip = 17'd65536;
            2: recip = RECIP_W'($urandom_range(0, 131071));
            default: recip = RECIP_W'(65536 / (n_eff * n_eff));
         endcase
         case ($urandom_range(0, 3))
            0: odd_pct = 0;
            1: odd_pct = 90;
            2: odd_pct = 100;
            default: odd_pct = 50;
         endcase
         steady_input = ($urandom_range(0, 3) == 0);
         set_config(bs, cols, mode, gain, recip);
         count = n_eff * n_eff * cols_eff * rows;
         // cut some sequences short
         if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count);
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         for (int k = 0; k < count; k++) begin
            send_pixel(rand_sample(odd_pct), (k == 0) || ($urandom_range(0, 199) == 0));
         end
         random_items += count;
         settle_block();
      end
      steady_input = 1'b0;
   endtask

   // Column count past the line width: the start of a row stays open.
   task automatic test_widest_row();
      set_config(1, 8191, MODE_DECODED, $urandom, 17'd65536);
      send_pixel(rand_sample(50), 1'b1);
      repeat (40) send_pixel(rand_sample(50), 1'b0);
      settle_block();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_operations();
      test_half_threshold();
      test_counter_overrun();
      test_backpressure();
      test_random_phases();
      test_widest_row();
      repeat (16) @(posedge clock);
      if (bad_fields == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Output stall: a pattern picked by stall_cycle bits 9:8, plus one long hold.
   always @(posedge clock) begin
      stall_cycle++;
      if (hold_request) begin
         hold_left = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_cycle[9:8])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= ($urandom_range(0, 9) < 6);
            default: rsp_stall <= (stall_cycle % 3 == 0);
         endcase
      end
   end

   function automatic void compare_field(input string name, input logic signed [63:0] want,
                                         input logic signed [63:0] got);
      if (got !== want) begin
         if (bad_fields < 50)
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
         bad_fields++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_averages.size() == 0) begin
            if (bad_fields < 50)
               $display("%0t ns: output pixel at column %0d with none pending",
                        $time, rsp_data.out_column);
            bad_fields++;
         end else begin
            want = pending_averages.pop_front();
            compare_field("value", want.value, rsp_data.value);
            compare_field("is_nan", want.is_nan, rsp_data.is_nan);
            compare_field("constraint_count", want.constraint_count,
                          rsp_data.constraint_count);
            compare_field("out_column", want.out_column, rsp_data.out_column);
            compare_field("last_in_row", want.last_in_row, rsp_data.last_in_row);
            compare_field("running_min", want.running_min, rsp_data.running_min);
            compare_field("running_max", want.running_max, rsp_data.running_max);
         end
      end
   end

   // Abort when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
